### rtl/core/efr_pkg.sv
// ----------------------------------------------------------------------------
// efr_pkg - shared types and constants of the eased fade ramp controller
// Fixed-point widths, command and curve codes, sequencer states, and the
// command structs that drive the serial divider and multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

package efr_pkg;

   localparam int TIME_BITS = 24;
   localparam int FRAC_BITS = 16;
   localparam int ALPHA_W   = FRAC_BITS + 1;
   localparam int DELTA_W   = 16;
   localparam int COLOR_W   = 16;
   localparam int CURVE_W   = 2;
   localparam int ACTION_W  = 3;

   // radix-4 shift-add multiplier: multiplicand is a Q1 value, multiplier
   // must hold 3.0 - 2t, so two integer bits, rounded up to whole digits
   localparam int MUL_A_W    = ALPHA_W;
   localparam int MUL_DIGITS = (FRAC_BITS + 3) / 2;
   localparam int MUL_B_W    = 2 * MUL_DIGITS;
   localparam int MUL_P_W    = MUL_A_W + MUL_B_W;
   localparam int MUL_CNT_W  = $clog2(MUL_DIGITS + 1);

   // restoring divider gives one quotient bit a cycle
   localparam int DIV_CNT_W  = $clog2(FRAC_BITS + 1);

   localparam logic [ALPHA_W-1:0]   Q_ONE    = {1'b1, {FRAC_BITS{1'b0}}};
   localparam logic [MUL_B_W-1:0]   Q_THREE  = MUL_B_W'(3 * (2 ** FRAC_BITS));
   localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

   typedef enum logic [ACTION_W-1:0] {
      ACT_TICK      = 3'd0,
      ACT_FADE_TO   = 3'd1,
      ACT_PLAY      = 3'd2,
      ACT_SET_ALPHA = 3'd3,
      ACT_STOP      = 3'd4,
      ACT_CLEAR     = 3'd5
   } action_type;

   typedef enum logic [CURVE_W-1:0] {
      CURVE_LINEAR   = 2'd0,
      CURVE_EASE_IN  = 2'd1,
      CURVE_EASE_OUT = 2'd2,
      CURVE_IN_OUT   = 2'd3
   } curve_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_SQUARE,
      ST_BLEND,
      ST_LERP,
      ST_REPORT
   } state_type;

   typedef struct packed {
      logic [COLOR_W-1:0] blue;
      logic [COLOR_W-1:0] green;
      logic [COLOR_W-1:0] red;
   } color_type;

   typedef struct packed {
      logic                 start;
      logic [TIME_BITS-1:0] num;
      logic [TIME_BITS-1:0] den;
   } div_cmd_type;

   typedef struct packed {
      logic               start;
      logic [MUL_A_W-1:0] mcand;
      logic [MUL_B_W-1:0] mplier;
   } mul_cmd_type;

   function automatic logic [ALPHA_W-1:0] clamp_one(input logic [ALPHA_W-1:0] v);
      return (v > Q_ONE) ? Q_ONE : v;
   endfunction

endpackage

`default_nettype wire

### rtl/core/efr_div.sv
// ----------------------------------------------------------------------------
// efr_div - bit-serial restoring divider
// Forms (num << FRAC_BITS) / den one quotient bit per cycle. The caller
// guarantees num < den, so the quotient is a pure fraction.
// ----------------------------------------------------------------------------
`default_nettype none

module efr_div
   import efr_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  div_cmd_type          cmd,
   output logic                 done,
   output logic [FRAC_BITS-1:0] quot
);

   logic [TIME_BITS-1:0] rem_ff, rem_in;
   logic [TIME_BITS-1:0] den_ff;
   logic [FRAC_BITS-1:0] quot_ff;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic                 busy_ff;
   logic                 done_ff;

   logic [TIME_BITS:0]   rem2;
   logic [TIME_BITS:0]   rem_sub;
   logic                 ge;

   always_comb begin
      rem2    = {rem_ff, 1'b0};
      rem_sub = rem2 - {1'b0, den_ff};
      ge      = (rem2 >= {1'b0, den_ff});
      // remainder stays below den, so it fits back in TIME_BITS
      rem_in  = ge ? rem_sub[TIME_BITS-1:0] : rem2[TIME_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (cmd.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= DIV_CNT_W'(FRAC_BITS);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - DIV_CNT_W'(1);
            if (cnt_ff == DIV_CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         rem_ff  <= cmd.num;
         den_ff  <= cmd.den;
         quot_ff <= '0;
      end else if (busy_ff) begin
         rem_ff  <= rem_in;
         quot_ff <= {quot_ff[FRAC_BITS-2:0], ge};
      end
   end

   assign done = done_ff;
   assign quot = quot_ff;

endmodule

`default_nettype wire

### rtl/core/efr_mul.sv
// ----------------------------------------------------------------------------
// efr_mul - radix-4 serial shift-add multiplier
// Takes two multiplier bits a cycle; the partial sum shifts right into the
// low half of the product register as the multiplier shifts out.
// ----------------------------------------------------------------------------
`default_nettype none

module efr_mul
   import efr_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  mul_cmd_type        cmd,
   output logic               done,
   output logic [MUL_P_W-1:0] product
);

   logic [MUL_A_W-1:0]   hi_ff, hi_in;
   logic [MUL_B_W-1:0]   lo_ff, lo_in;
   logic [MUL_A_W-1:0]   a_ff;
   logic [MUL_A_W+1:0]   a3_ff, a3_in;
   logic [MUL_CNT_W-1:0] cnt_ff;
   logic                 busy_ff;
   logic                 done_ff;

   logic [MUL_A_W+1:0]   addend;
   logic [MUL_A_W+1:0]   sum;

   always_comb begin
      unique case (lo_ff[1:0])
         2'd0:    addend = '0;
         2'd1:    addend = {2'b00, a_ff};
         2'd2:    addend = {1'b0, a_ff, 1'b0};
         2'd3:    addend = a3_ff;
         default: addend = '0;
      endcase
      sum   = {2'b00, hi_ff} + addend;
      hi_in = sum[MUL_A_W+1:2];
      lo_in = {sum[1:0], lo_ff[MUL_B_W-1:2]};
      a3_in = {2'b00, cmd.mcand} + {1'b0, cmd.mcand, 1'b0};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (cmd.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= MUL_CNT_W'(MUL_DIGITS);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - MUL_CNT_W'(1);
            if (cnt_ff == MUL_CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         hi_ff <= '0;
         lo_ff <= cmd.mplier;
         a_ff  <= cmd.mcand;
         a3_ff <= a3_in;
      end else if (busy_ff) begin
         hi_ff <= hi_in;
         lo_ff <= lo_in;
      end
   end

   assign done    = done_ff;
   assign product = {hi_ff, lo_ff};

endmodule

`default_nettype wire

### rtl/core/eased_fade_ramp_controller.sv
// ----------------------------------------------------------------------------
// eased_fade_ramp_controller - Q1.16 fade ramp with easing curves
// Holds a fade alpha and colour; commands start, advance, set, stop or clear
// a timed ramp, and every command returns one result item.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one command item; it is taken when req_valid is high and
//   req_stall is low. rsp_* returns the resulting state (enabled, alpha,
//   colour, playing), one item per command, taken when rsp_valid is high and
//   rsp_stall is low.
//   Commands other than a running tick go straight to the report step; the
//   result is registered there once the output register is free.
//   Running tick: t = elapsed/length comes from a serial divider, then 1 to 3
//   passes through a radix-4 multiplier (curve, then the lerp): one pass for
//   linear, two for ease in/out, three for ease in-out. A tick that ends the
//   ramp skips the divider and multiplier, like a plain command.
//   One item is in work at a time: the next item can be taken once the
//   sequencer returns to idle after its report step. req_stall is low
//   whenever the sequencer is idle, even while a finished result waits in the
//   output register.
//   A stalled result holds; the sequencer waits in its report step until the
//   output register is free.
//   Reset (synchronous, active high) clears the ramp, alpha and colour to
//   zero, the same as a clear command.
// ----------------------------------------------------------------------------
`default_nettype none

module eased_fade_ramp_controller
   import efr_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,

   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [ACTION_W-1:0]  req_action,
   input  logic [DELTA_W-1:0]   req_delta_time,
   input  logic [ALPHA_W-1:0]   req_target_alpha,
   input  logic [ALPHA_W-1:0]   req_start_alpha,
   input  logic [TIME_BITS-1:0] req_duration,
   input  logic [CURVE_W-1:0]   req_curve,
   input  logic [COLOR_W-1:0]   req_color_red,
   input  logic [COLOR_W-1:0]   req_color_green,
   input  logic [COLOR_W-1:0]   req_color_blue,

   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic                 rsp_enabled,
   output logic [ALPHA_W-1:0]   rsp_alpha_out,
   output logic [COLOR_W-1:0]   rsp_red_out,
   output logic [COLOR_W-1:0]   rsp_green_out,
   output logic [COLOR_W-1:0]   rsp_blue_out,
   output logic                 rsp_playing
);

   state_type            state_ff, state_in;

   logic                 running_ff, running_in;
   logic [TIME_BITS-1:0] elapsed_ff, elapsed_in;
   logic [ALPHA_W-1:0]   alpha_ff, alpha_in;
   color_type            color_ff, color_in;
   logic [ALPHA_W-1:0]   from_ff, from_in;
   logic [ALPHA_W-1:0]   to_ff, to_in;
   logic [TIME_BITS-1:0] len_ff, len_in;
   logic [CURVE_W-1:0]   curve_ff, curve_in;
   color_type            rcolor_ff, rcolor_in;

   logic                 rsp_valid_ff;
   logic                 rsp_enabled_ff;
   logic [ALPHA_W-1:0]   rsp_alpha_ff;
   color_type            rsp_color_ff;
   logic                 rsp_playing_ff;

   div_cmd_type          div_cmd;
   logic                 div_done;
   logic [FRAC_BITS-1:0] div_quot;
   mul_cmd_type          mul_cmd;
   logic                 mul_done;
   logic [MUL_P_W-1:0]   mul_product;

   logic                 accept;
   logic                 out_free;
   logic                 rsp_load;
   logic                 tick_work;
   logic [TIME_BITS:0]   esum;
   logic [TIME_BITS-1:0] esat;
   logic                 ramp_end;
   logic [ALPHA_W-1:0]   t_ext;
   logic [ALPHA_W-1:0]   u_val;
   logic [ALPHA_W-1:0]   prod_hi;
   logic [MUL_B_W-1:0]   blend_factor;
   logic                 rising;
   logic [ALPHA_W-1:0]   diff;
   color_type            req_color;

   efr_div u_div (
      .clock (clock),
      .reset (reset),
      .cmd   (div_cmd),
      .done  (div_done),
      .quot  (div_quot)
   );

   efr_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .cmd     (mul_cmd),
      .done    (mul_done),
      .product (mul_product)
   );

   // shared arithmetic
   always_comb begin
      accept       = req_valid && !req_stall;
      out_free     = !rsp_valid_ff || !rsp_stall;
      rsp_load     = (state_ff == ST_REPORT) && out_free;
      esum         = {1'b0, elapsed_ff} + (TIME_BITS + 1)'(req_delta_time);
      esat         = esum[TIME_BITS] ? TIME_MAX : esum[TIME_BITS-1:0];
      // t reaches 1.0 exactly when elapsed catches up with the length
      ramp_end     = (esat >= len_ff);
      tick_work    = accept && (req_action == ACT_TICK) && running_ff && !ramp_end;
      t_ext        = {1'b0, div_quot};
      u_val        = Q_ONE - t_ext;
      prod_hi      = mul_product[FRAC_BITS+ALPHA_W-1:FRAC_BITS];
      blend_factor = Q_THREE - {{(MUL_B_W-FRAC_BITS-1){1'b0}}, div_quot, 1'b0};
      rising       = (to_ff >= from_ff);
      diff         = rising ? (to_ff - from_ff) : (from_ff - to_ff);
      req_color    = '{blue: req_color_blue, green: req_color_green, red: req_color_red};
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = tick_work ? ST_DIVIDE : ST_REPORT;
            end
         end
         ST_DIVIDE: begin
            if (div_done) begin
               state_in = (curve_ff == CURVE_LINEAR) ? ST_LERP : ST_SQUARE;
            end
         end
         ST_SQUARE: begin
            if (mul_done) begin
               state_in = (curve_ff == CURVE_IN_OUT) ? ST_BLEND : ST_LERP;
            end
         end
         ST_BLEND: begin
            if (mul_done) begin
               state_in = ST_LERP;
            end
         end
         ST_LERP: begin
            if (mul_done) begin
               state_in = ST_REPORT;
            end
         end
         ST_REPORT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs: handshake and unit launches
   always_comb begin
      req_stall      = (state_ff != ST_IDLE);
      div_cmd.start  = tick_work;
      div_cmd.num    = esat;
      div_cmd.den    = len_ff;
      mul_cmd.start  = 1'b0;
      mul_cmd.mcand  = '0;
      mul_cmd.mplier = '0;
      unique case (state_ff)
         ST_DIVIDE: begin
            mul_cmd.start = div_done;
            unique case (curve_ff)
               CURVE_LINEAR: begin
                  mul_cmd.mcand  = diff;
                  mul_cmd.mplier = MUL_B_W'(t_ext);
               end
               CURVE_EASE_OUT: begin
                  mul_cmd.mcand  = u_val;
                  mul_cmd.mplier = MUL_B_W'(u_val);
               end
               CURVE_EASE_IN, CURVE_IN_OUT: begin
                  mul_cmd.mcand  = t_ext;
                  mul_cmd.mplier = MUL_B_W'(t_ext);
               end
               default: begin
                  mul_cmd.mcand  = t_ext;
                  mul_cmd.mplier = MUL_B_W'(t_ext);
               end
            endcase
         end
         ST_SQUARE: begin
            mul_cmd.start = mul_done;
            unique case (curve_ff)
               CURVE_IN_OUT: begin
                  mul_cmd.mcand  = prod_hi;
                  mul_cmd.mplier = blend_factor;
               end
               CURVE_EASE_OUT: begin
                  mul_cmd.mcand  = diff;
                  mul_cmd.mplier = MUL_B_W'(Q_ONE - prod_hi);
               end
               default: begin
                  mul_cmd.mcand  = diff;
                  mul_cmd.mplier = MUL_B_W'(prod_hi);
               end
            endcase
         end
         ST_BLEND: begin
            mul_cmd.start  = mul_done;
            mul_cmd.mcand  = diff;
            mul_cmd.mplier = MUL_B_W'(prod_hi);
         end
         default: begin
            mul_cmd.start = 1'b0;
         end
      endcase
   end

   // ramp state updates
   always_comb begin
      running_in = running_ff;
      elapsed_in = elapsed_ff;
      alpha_in   = alpha_ff;
      color_in   = color_ff;
      from_in    = from_ff;
      to_in      = to_ff;
      len_in     = len_ff;
      curve_in   = curve_ff;
      rcolor_in  = rcolor_ff;
      if ((state_ff == ST_IDLE) && accept) begin
         unique case (req_action)
            ACT_TICK: begin
               if (running_ff) begin
                  elapsed_in = esat;
                  color_in   = rcolor_ff;
                  if (ramp_end) begin
                     alpha_in   = to_ff;
                     running_in = 1'b0;
                  end
               end
            end
            ACT_FADE_TO, ACT_PLAY: begin
               from_in    = (req_action == ACT_PLAY) ? clamp_one(req_start_alpha) : alpha_ff;
               to_in      = clamp_one(req_target_alpha);
               len_in     = req_duration;
               curve_in   = req_curve;
               rcolor_in  = req_color;
               elapsed_in = '0;
               color_in   = req_color;
               if (req_duration == '0) begin
                  alpha_in   = clamp_one(req_target_alpha);
                  running_in = 1'b0;
               end else begin
                  alpha_in   = from_in;
                  running_in = 1'b1;
               end
            end
            ACT_SET_ALPHA: begin
               running_in = 1'b0;
               elapsed_in = '0;
               alpha_in   = clamp_one(req_target_alpha);
               color_in   = req_color;
               from_in    = '0;
               to_in      = '0;
               len_in     = '0;
               curve_in   = CURVE_LINEAR;
               rcolor_in  = '0;
            end
            ACT_STOP: begin
               running_in = 1'b0;
               elapsed_in = '0;
            end
            ACT_CLEAR: begin
               running_in = 1'b0;
               elapsed_in = '0;
               alpha_in   = '0;
               color_in   = '0;
               from_in    = '0;
               to_in      = '0;
               len_in     = '0;
               curve_in   = CURVE_LINEAR;
               rcolor_in  = '0;
            end
            default: begin
               running_in = running_ff;
            end
         endcase
      end else if ((state_ff == ST_LERP) && mul_done) begin
         // step is truncated, so rounding is toward the start alpha
         alpha_in = rising ? (from_ff + prod_hi) : (from_ff - prod_hi);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         running_ff   <= 1'b0;
         elapsed_ff   <= '0;
         alpha_ff     <= '0;
         color_ff     <= '0;
         from_ff      <= '0;
         to_ff        <= '0;
         len_ff       <= '0;
         curve_ff     <= CURVE_LINEAR;
         rcolor_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         running_ff <= running_in;
         elapsed_ff <= elapsed_in;
         alpha_ff   <= alpha_in;
         color_ff   <= color_in;
         from_ff    <= from_in;
         to_ff      <= to_in;
         len_ff     <= len_in;
         curve_ff   <= curve_in;
         rcolor_ff  <= rcolor_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_enabled_ff <= running_ff || (alpha_ff != '0);
         rsp_alpha_ff   <= alpha_ff;
         rsp_color_ff   <= color_ff;
         rsp_playing_ff <= running_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_enabled   = rsp_enabled_ff;
   assign rsp_alpha_out = rsp_alpha_ff;
   assign rsp_red_out   = rsp_color_ff.red;
   assign rsp_green_out = rsp_color_ff.green;
   assign rsp_blue_out  = rsp_color_ff.blue;
   assign rsp_playing   = rsp_playing_ff;

   // a running ramp always has a nonzero length, so the divider never sees zero
   a_running_has_length: assert property (@(posedge clock) disable iff (reset)
      running_ff |-> (len_ff != '0))
      else $error("ramp running with zero length");

   a_alpha_in_range: assert property (@(posedge clock) disable iff (reset)
      alpha_ff <= Q_ONE)
      else $error("alpha above one");

   a_clear_resets: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && (req_action == ACT_CLEAR))
      |=> (!running_ff && (alpha_ff == '0) && (len_ff == '0)))
      else $error("clear command left ramp state behind");

   a_one_unit_launch: assert property (@(posedge clock) disable iff (reset)
      !(div_cmd.start && mul_cmd.start))
      else $error("divider and multiplier launched together");

endmodule

`default_nettype wire
